[src/assert_macros.svh]
// Assertion macros shared by the pixel block OR-pooling RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a consequence in the same cycle as its antecedent
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a consequence in the cycle after its antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)

`endif

`endif

[src/pbod_pkg.sv]
// Package for the pixel block OR-pooling block: constants, register codes,
// payload structs and the position flags passed from control to datapath.
// Depends on nothing.
package pbod_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_BLOCK_SIZE = 4;
    localparam int ROW_LIMIT      = 1024;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int ROW_W          = 10;
    localparam int RST_WIDTH      = 640;
    localparam int RST_HEIGHT     = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } pixel_t;

    typedef struct packed {
        logic       block_marked;
        logic [7:0] block_col;
        logic [7:0] block_row;
        logic       last_block;
    } block_t;

    // Where the next pixel falls relative to the block grid
    typedef struct packed {
        logic in_grid;
        logic col_first;
        logic col_last;
        logic row_first;
        logic emits;
        logic last_block;
    } pos_flags_t;

endpackage

[src/pbod_ctrl.sv]
// Control for the pixel block OR-pooling block: size registers, raster
// counters and block-grid position flags. Depends on pbod_pkg, assert_macros.svh.
`include "assert_macros.svh"

module pbod_ctrl
    import pbod_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
    localparam int CW_RAW    = $clog2(MAX_WIDTH + 2 * BLOCK_SIZE + 1),
    localparam int CW        = (CW_RAW > CFG_W) ? CW_RAW : CFG_W,
    localparam int RW_RAW    = $clog2(ROW_LIMIT + 2 * BLOCK_SIZE + 1),
    localparam int RW        = (RW_RAW > CFG_W) ? RW_RAW : CFG_W,
    localparam int KW        = $clog2(BLOCK_SIZE),
    localparam int BCW_RAW   = $clog2((MAX_WIDTH - 1) / BLOCK_SIZE + 1),
    localparam int BCW       = (BCW_RAW > 1) ? BCW_RAW : 1,
    localparam int BRW_RAW   = $clog2((ROW_LIMIT - 1) / BLOCK_SIZE + 1),
    localparam int BRW       = (BRW_RAW > 1) ? BRW_RAW : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output pos_flags_t           flags,
    output logic [BCW-1:0]       bc,
    output logic [BRW-1:0]       br
);

    localparam int RST_W_EFF = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_H_EFF = (RST_HEIGHT > ROW_LIMIT) ? ROW_LIMIT : RST_HEIGHT;

    logic [CW-1:0]    eff_w_reg, eff_w_next;
    logic [RW-1:0]    eff_h_reg, eff_h_next;
    logic [CW-1:0]    w_raw;
    logic [RW-1:0]    h_raw;

    logic [CW-1:0]    col_reg, col_next;
    logic [KW-1:0]    cin_reg, cin_next;
    logic [BCW-1:0]   bc_reg, bc_next;
    logic [CW-1:0]    bend_reg, bend_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [KW-1:0]    rin_reg, rin_next;
    logic [BRW-1:0]   br_reg, br_next;
    logic [RW-1:0]    rend_reg, rend_next;

    logic col_wrap, row_wrap, cin_last, rin_last;
    logic in_x, in_y, last_x, last_y;

    // Clamp written sizes to the supported range
    assign w_raw = CW'(cfg_data);
    assign h_raw = RW'(cfg_data);

    always_comb
    begin
        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    if (w_raw > CW'(MAX_WIDTH))
                        eff_w_next = CW'(MAX_WIDTH);
                    else if (w_raw == '0)
                        eff_w_next = CW'(1);
                    else
                        eff_w_next = w_raw;
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (h_raw > RW'(ROW_LIMIT))
                        eff_h_next = RW'(ROW_LIMIT);
                    else if (h_raw == '0)
                        eff_h_next = RW'(1);
                    else
                        eff_h_next = h_raw;
                end
                default:
                begin
                    eff_w_next = eff_w_reg;
                    eff_h_next = eff_h_reg;
                end
            endcase
        end
    end

    // Detect row, image and block boundaries
    assign col_wrap = (col_reg + CW'(1)) == eff_w_reg;
    assign row_wrap = (RW'(row_reg) + RW'(1)) == eff_h_reg;
    assign cin_last = cin_reg == KW'(BLOCK_SIZE - 1);
    assign rin_last = rin_reg == KW'(BLOCK_SIZE - 1);

    // Advance the raster counters; any register write restarts the image
    always_comb
    begin
        col_next  = col_reg;
        cin_next  = cin_reg;
        bc_next   = bc_reg;
        bend_next = bend_reg;
        row_next  = row_reg;
        rin_next  = rin_reg;
        br_next   = br_reg;
        rend_next = rend_reg;
        if (cfg_we)
        begin
            col_next  = '0;
            cin_next  = '0;
            bc_next   = '0;
            bend_next = CW'(BLOCK_SIZE);
            row_next  = '0;
            rin_next  = '0;
            br_next   = '0;
            rend_next = RW'(BLOCK_SIZE);
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_next  = '0;
                cin_next  = '0;
                bc_next   = '0;
                bend_next = CW'(BLOCK_SIZE);
                if (row_wrap)
                begin
                    row_next  = '0;
                    rin_next  = '0;
                    br_next   = '0;
                    rend_next = RW'(BLOCK_SIZE);
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    if (rin_last)
                    begin
                        rin_next  = '0;
                        br_next   = br_reg + BRW'(1);
                        rend_next = rend_reg + RW'(BLOCK_SIZE);
                    end
                    else
                    begin
                        rin_next = rin_reg + KW'(1);
                    end
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
                if (cin_last)
                begin
                    cin_next  = '0;
                    bc_next   = bc_reg + BCW'(1);
                    bend_next = bend_reg + CW'(BLOCK_SIZE);
                end
                else
                begin
                    cin_next = cin_reg + KW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= CW'(RST_W_EFF);
            eff_h_reg <= RW'(RST_H_EFF);
            col_reg   <= '0;
            cin_reg   <= '0;
            bc_reg    <= '0;
            bend_reg  <= CW'(BLOCK_SIZE);
            row_reg   <= '0;
            rin_reg   <= '0;
            br_reg    <= '0;
            rend_reg  <= RW'(BLOCK_SIZE);
        end
        else
        begin
            eff_w_reg <= eff_w_next;
            eff_h_reg <= eff_h_next;
            col_reg   <= col_next;
            cin_reg   <= cin_next;
            bc_reg    <= bc_next;
            bend_reg  <= bend_next;
            row_reg   <= row_next;
            rin_reg   <= rin_next;
            br_reg    <= br_next;
            rend_reg  <= rend_next;
        end
    end

    // A block lies in the grid when its right (bottom) edge fits the image
    assign in_x   = bend_reg <= eff_w_reg;
    assign in_y   = rend_reg <= eff_h_reg;
    assign last_x = (bend_reg + CW'(BLOCK_SIZE)) > eff_w_reg;
    assign last_y = (rend_reg + RW'(BLOCK_SIZE)) > eff_h_reg;

    assign flags.in_grid    = in_x && in_y;
    assign flags.col_first  = cin_reg == '0;
    assign flags.col_last   = cin_last;
    assign flags.row_first  = rin_reg == '0;
    assign flags.emits      = in_x && in_y && cin_last && rin_last;
    assign flags.last_block = last_x && last_y;

    assign bc = bc_reg;
    assign br = br_reg;

    `ASSERT_NEXT_CYCLE(a_cfg_restart, clk, rst_n, cfg_we, col_reg == '0 && row_reg == '0)
    `ASSERT_SAME_CYCLE(a_col_start, clk, rst_n, col_reg == '0, cin_reg == '0 && bc_reg == '0 && bend_reg == CW'(BLOCK_SIZE))
    `ASSERT_SAME_CYCLE(a_row_start, clk, rst_n, row_reg == '0, rin_reg == '0 && br_reg == '0 && rend_reg == RW'(BLOCK_SIZE))

endmodule

[src/pbod_pool.sv]
// Datapath for the pixel block OR-pooling block: mark detection, row-segment
// OR, per-block-column line store and result register. Depends on pbod_pkg.
module pbod_pool
    import pbod_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
    localparam int BCW_RAW   = $clog2((MAX_WIDTH - 1) / BLOCK_SIZE + 1),
    localparam int BCW       = (BCW_RAW > 1) ? BCW_RAW : 1,
    localparam int BRW_RAW   = $clog2((ROW_LIMIT - 1) / BLOCK_SIZE + 1),
    localparam int BRW       = (BRW_RAW > 1) ? BRW_RAW : 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  pixel_t         pixel,
    input  pos_flags_t     flags,
    input  logic [BCW-1:0] bc,
    input  logic [BRW-1:0] br,
    input  logic           result_ready,
    output logic           result_valid,
    output block_t         result
);

    localparam int LINE_DEPTH = (MAX_WIDTH / BLOCK_SIZE > 1) ? MAX_WIDTH / BLOCK_SIZE : 1;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic                 line_mem [LINE_DEPTH];
    logic                 rd_reg;
    logic                 acc_reg;
    logic                 mark;
    logic                 seg;
    logic                 merged;
    logic [AW-1:0]        addr;
    logic [BCW+7:0]       bc_ext;
    logic [BRW+7:0]       br_ext;
    logic                 valid_reg, valid_next;
    block_t               result_reg, result_next;

    // A pixel is marked when it is pure black
    assign mark = (pixel.pixel_red | pixel.pixel_green | pixel.pixel_blue) == 8'd0;

    // OR across the pixels of this block in the current row
    assign seg    = (flags.col_first ? 1'b0 : acc_reg) | mark;
    // Fold in the rows above, or start fresh on the block's first row
    assign merged = flags.row_first ? seg : (rd_reg | seg);
    assign addr   = bc[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
            acc_reg <= seg;
    end

    // Line store: read at the block's first column, write back at its last
    always_ff @(posedge clk)
    begin
        if (accept && flags.in_grid && flags.col_last)
            line_mem[addr] <= merged;
        if (accept && flags.in_grid && flags.col_first)
            rd_reg <= line_mem[addr];
    end

    // Load a result on the block's last pixel, drop valid once taken
    assign bc_ext = {8'd0, bc};
    assign br_ext = {8'd0, br};

    always_comb
    begin
        result_next = result_reg;
        valid_next  = valid_reg;
        if (accept && flags.emits)
        begin
            result_next.block_marked = merged;
            result_next.block_col    = bc_ext[7:0];
            result_next.block_row    = br_ext[7:0];
            result_next.last_block   = flags.last_block;
            valid_next               = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

[src/pixel_block_or_downsample_top.sv]
// Pixel block OR-pooling block: top level tying control and datapath.
// Depends on pbod_pkg, pbod_ctrl, pbod_pool, assert_macros.svh.
//
// Takes RGB pixels in raster order and returns one bit per full
// BLOCK_SIZE x BLOCK_SIZE block, set when any pixel of the block is pure
// black. A result comes out in the cycle after the block's bottom-right pixel;
// partial blocks at the right and bottom edges give none. The block takes
// one pixel every cycle: pixel_ready drops only when the next pixel would
// complete a block while the previous result is still waiting on the block
// channel. Per-block-column partial ORs live in a MAX_WIDTH/BLOCK_SIZE by
// 1-bit line store with one write and one registered read port, read at a
// block's first column and written at its last. Writing either size register
// restarts the image at the top-left pixel; do so only while no transaction
// is in flight.
`include "assert_macros.svh"

module pixel_block_or_downsample_top
    import pbod_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  pixel_t               pixel,
    output logic                 block_valid,
    input  logic                 block_ready,
    output block_t               block,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int BCW_RAW = $clog2((MAX_WIDTH - 1) / BLOCK_SIZE + 1);
    localparam int BCW     = (BCW_RAW > 1) ? BCW_RAW : 1;
    localparam int BRW_RAW = $clog2((ROW_LIMIT - 1) / BLOCK_SIZE + 1);
    localparam int BRW     = (BRW_RAW > 1) ? BRW_RAW : 1;

    pos_flags_t     flags;
    logic [BCW-1:0] bc;
    logic [BRW-1:0] br;
    logic           accept;

    // Stall only a pixel that would complete a block while a result waits
    assign pixel_ready = !block_valid || block_ready || !flags.emits;
    assign accept      = pixel_valid && pixel_ready;

    pbod_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flags     (flags),
        .bc        (bc),
        .br        (br)
    );

    pbod_pool #(
        .MAX_WIDTH  (MAX_WIDTH),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_pool (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pixel        (pixel),
        .flags        (flags),
        .bc           (bc),
        .br           (br),
        .result_ready (block_ready),
        .result_valid (block_valid),
        .result       (block)
    );

    `ASSERT_SAME_CYCLE(a_no_overwrite, clk, rst_n, accept && flags.emits, !block_valid || block_ready)
    `ASSERT_NEXT_CYCLE(a_result_follows, clk, rst_n, accept && flags.emits, block_valid)
    `ASSERT_NEXT_CYCLE(a_stall_holds, clk, rst_n, accept && !flags.emits && block_valid && !block_ready, block_valid)

endmodule
